// ----- rtl/hkrf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrf_pkg
// Shared types, constants and the control program of the keyboard report
// framer.
// ----------------------------------------------------------------------------
package hkrf_pkg;

	localparam int KEY_SLOTS_DEF  = 6;
	localparam int LAYOUT_ENTRIES = 128;
	localparam int LAYOUT_AW      = $clog2(LAYOUT_ENTRIES);
	localparam int CFG_IW         = 3;
	localparam int FRAME_HDR_LEN  = 7;

	// Command codes
	typedef enum logic [1:0] {
		CMD_PRESS       = 2'd0,
		CMD_RELEASE     = 2'd1,
		CMD_RELEASE_ALL = 2'd2,
		CMD_LOAD        = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] REG_OUTPUT_ENABLE   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_SHIFT_FLAG      = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ALTGR_FLAG      = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ISO_REPLACEMENT = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ISO_KEY         = 3'd4;

	// Frame header bytes
	localparam logic [7:0] HDR_SYNC0 = 8'h57;
	localparam logic [7:0] HDR_SYNC1 = 8'hAB;
	localparam logic [7:0] HDR_ADDR  = 8'h00;
	localparam logic [7:0] HDR_CMD   = 8'h02;

	// Key code mapping
	localparam logic [7:0] MOD_ALTGR  = 8'h40;
	localparam logic [7:0] MOD_SHIFT  = 8'h02;
	localparam logic [7:0] MASK_ALTGR = 8'h3F;
	localparam logic [7:0] MASK_SHIFT = 8'h7F;
	localparam logic [7:0] RAW_BASE   = 8'd136;
	localparam logic [7:0] GUI_LO     = 8'hE0;
	localparam logic [7:0] GUI_END    = 8'hE8;

	// Reset values of the configuration registers
	localparam logic [7:0] SHIFT_FLAG_RST = 8'd128;
	localparam logic [7:0] ALTGR_FLAG_RST = 8'd192;
	localparam logic [7:0] ISO_REPL_RST   = 8'd50;
	localparam logic [7:0] ISO_KEY_RST    = 8'd100;

	// Datapath operations selected by the control word
	typedef enum logic [2:0] {
		OP_IDLE   = 3'd0,
		OP_MAP    = 3'd1,
		OP_SLOT   = 3'd2,
		OP_EMIT   = 3'd3,
		OP_SINGLE = 3'd4
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS  = 3'd0,
		C_ACCEPT  = 3'd1,
		C_NOFRAME = 3'd2,
		C_SKIP    = 3'd3,
		C_LAST    = 3'd4
	} cond_t;

	// Program steps
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_MAP    = 3'd1,
		ST_SLOT   = 3'd2,
		ST_FRAME  = 3'd3,
		ST_SINGLE = 3'd4
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;
		step_t target;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic go;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic accept;
		logic noframe;
		logic skip;
		logic last;
		logic out_busy;
	} stat_t;

	// Control program: jump to target when cond holds, else stay when hold
	// is set, else fall through to the next step.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_IDLE:   w = '{op: OP_IDLE,   cond: C_ACCEPT,  hold: 1'b1, target: ST_MAP};
			ST_MAP:    w = '{op: OP_MAP,    cond: C_NOFRAME, hold: 1'b0, target: ST_SINGLE};
			ST_SLOT:   w = '{op: OP_SLOT,   cond: C_SKIP,    hold: 1'b0, target: ST_SINGLE};
			ST_FRAME:  w = '{op: OP_EMIT,   cond: C_LAST,    hold: 1'b1, target: ST_IDLE};
			ST_SINGLE: w = '{op: OP_SINGLE, cond: C_ALWAYS,  hold: 1'b0, target: ST_IDLE};
			default:   w = '{op: OP_IDLE,   cond: C_ALWAYS,  hold: 1'b0, target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/hkrf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrf_cmd_if / hkrf_frame_if
// Valid/ready channels for commands in and frame bytes out.
// ----------------------------------------------------------------------------
interface hkrf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] key_code;
	logic [6:0] layout_index;
	logic [7:0] layout_value;

	modport source (output valid, cmd, key_code, layout_index, layout_value, input ready);
	modport sink   (input valid, cmd, key_code, layout_index, layout_value, output ready);
endinterface

interface hkrf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       byte_valid;
	logic       last;
	logic       status;

	modport source (output valid, frame_byte, byte_valid, last, status, input ready);
	modport sink   (input valid, frame_byte, byte_valid, last, status, output ready);
endinterface

// ----- rtl/hid_key_report_framer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_report_framer_unit
// Keyboard report keeper and serial frame builder driven by a microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command per transaction: press, release, release all,
//   or load one layout table entry. frame_ch returns the results: for a
//   command that sends a report, 8+KEY_SLOTS frame bytes (header, modifiers,
//   zero, key slots, byte-sum checksum) with last on the checksum byte;
//   otherwise a single transaction with byte_valid low, last high and status
//   set for a rejected press.
//   Timing: the command is taken in the idle step, the key is mapped in the
//   next cycle (layout RAM read is registered), slots are updated in the
//   cycle after, then one frame byte leaves per cycle while frame_ch does
//   not stall. The next command is taken as soon as the last result has
//   entered the output register, so a waiting result does not block it.
//   If frame_ch stalls, the program holds on the current byte.
//   Reset clears the report, all layout valid bits (every character reads as
//   unmapped) and loads the register defaults. Configuration is written
//   through cfg_we/cfg_index/cfg_wdata while no command is in flight.
// ----------------------------------------------------------------------------
module hid_key_report_framer_unit #(
	parameter int KEY_SLOTS = hkrf_pkg::KEY_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hkrf_pkg::CFG_IW-1:0] cfg_index,
	input  logic [7:0]                  cfg_wdata,
	hkrf_cmd_if.sink                    cmd_ch,
	hkrf_frame_if.source                frame_ch
);

	localparam int FRAME_LEN = hkrf_pkg::FRAME_HDR_LEN + KEY_SLOTS + 1;
	localparam int BYTE_W    = $clog2(FRAME_LEN);
	localparam int SLOT_IW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(FRAME_LEN - 1);
	localparam logic [BYTE_W-1:0] SLOT0_IDX = BYTE_W'(hkrf_pkg::FRAME_HDR_LEN);
	localparam logic [7:0] LEN_BYTE = 8'(KEY_SLOTS + 2);

	// configuration
	logic       oe_q;
	logic [7:0] shift_q;
	logic [7:0] altgr_q;
	logic [7:0] iso_repl_q;
	logic [7:0] iso_key_q;

	// report state
	logic [7:0] mod_q;
	logic [7:0] slots_q [KEY_SLOTS];
	logic [hkrf_pkg::LAYOUT_ENTRIES-1:0] lay_vld_q;

	// per-command working registers
	logic [1:0]        cmd_q;
	logic [7:0]        key_q;
	logic              ent_vld_q;
	logic [7:0]        code_q;
	logic              status_q;
	logic [BYTE_W-1:0] byte_q;
	logic [7:0]        sum_q;

	// output register
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_bv_q;
	logic       out_last_q;
	logic       out_st_q;

	hkrf_pkg::ctl_t  ctl;
	hkrf_pkg::stat_t stat;

	logic       accept;
	logic       ram_we;
	logic [7:0] ram_rdata;
	logic       out_busy;
	logic       out_load;

	// mapping
	logic [7:0] entry;
	logic       alt_hit;
	logic       shf_hit;
	logic [7:0] tbl_mod;
	logic [7:0] tbl_code;
	logic [7:0] raw_bit;
	logic [7:0] map_code;
	logic [7:0] mod_set;
	logic [7:0] mod_clr;
	logic       map_noframe;
	logic       map_rej;

	// slot search
	logic [KEY_SLOTS-1:0] hit;
	logic [KEY_SLOTS-1:0] empty;
	logic                 present;
	logic                 free;
	logic [SLOT_IW-1:0]   free_idx;
	logic                 found;
	logic                 slot_rej;

	// frame byte
	logic [SLOT_IW-1:0] byte_slot;
	logic [7:0]         cur_byte;
	logic               at_last;

	assign cmd_ch.ready = (ctl.op == hkrf_pkg::OP_IDLE);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign ram_we       = accept && (cmd_ch.cmd == hkrf_pkg::CMD_LOAD);

	hkrf_ram #(
		.WIDTH (8),
		.DEPTH (hkrf_pkg::LAYOUT_ENTRIES)
	) u_layout (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_ch.layout_index),
		.wdata (cmd_ch.layout_value),
		.raddr (cmd_ch.key_code[hkrf_pkg::LAYOUT_AW-1:0]),
		.rdata (ram_rdata)
	);

	hkrf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// Map the latched key to a usage code and a modifier change.
	always_comb begin
		entry   = ent_vld_q ? ram_rdata : 8'h00;
		alt_hit = (entry & altgr_q) == altgr_q;
		shf_hit = (entry & shift_q) == shift_q;
		if (alt_hit) begin
			tbl_mod  = hkrf_pkg::MOD_ALTGR;
			tbl_code = entry & hkrf_pkg::MASK_ALTGR;
		end else if (shf_hit) begin
			tbl_mod  = hkrf_pkg::MOD_SHIFT;
			tbl_code = entry & hkrf_pkg::MASK_SHIFT;
		end else begin
			tbl_mod  = 8'h00;
			tbl_code = entry;
		end
		if (tbl_code == iso_repl_q) begin
			tbl_code = iso_key_q;
		end
		raw_bit     = 8'(8'd1 << key_q[2:0]);
		map_code    = 8'h00;
		mod_set     = 8'h00;
		mod_clr     = 8'h00;
		map_noframe = 1'b0;
		map_rej     = 1'b0;
		case (cmd_q)
			hkrf_pkg::CMD_PRESS: begin
				// GUI keys pass unchanged on press only
				if (key_q >= hkrf_pkg::GUI_LO && key_q < hkrf_pkg::GUI_END) begin
					map_code = key_q;
				end else if (key_q >= hkrf_pkg::RAW_BASE) begin
					map_code = key_q - hkrf_pkg::RAW_BASE;
				end else if (key_q[7]) begin
					mod_set = raw_bit;
				end else if (entry == 8'h00) begin
					map_noframe = 1'b1;
					map_rej     = 1'b1;
				end else begin
					mod_set  = tbl_mod;
					map_code = tbl_code;
				end
			end
			hkrf_pkg::CMD_RELEASE: begin
				if (key_q >= hkrf_pkg::RAW_BASE) begin
					map_code = key_q - hkrf_pkg::RAW_BASE;
				end else if (key_q[7]) begin
					mod_clr = raw_bit;
				end else if (entry == 8'h00) begin
					map_noframe = 1'b1;
				end else begin
					mod_clr  = tbl_mod;
					map_code = tbl_code;
				end
			end
			hkrf_pkg::CMD_RELEASE_ALL: begin
				map_noframe = 1'b0;
			end
			default: begin
				map_noframe = 1'b1;
			end
		endcase
	end

	// Compare the code against every slot; pick the lowest empty one.
	always_comb begin
		free_idx = '0;
		found    = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit[i]   = (slots_q[i] == code_q);
			empty[i] = (slots_q[i] == 8'h00);
			if (empty[i] && !found) begin
				free_idx = SLOT_IW'(i);
				found    = 1'b1;
			end
		end
		present  = |hit;
		free     = |empty;
		slot_rej = (cmd_q == hkrf_pkg::CMD_PRESS) && !present && !free;
	end

	// Select the frame byte for the current position.
	assign byte_slot = SLOT_IW'(byte_q - SLOT0_IDX);
	assign at_last   = (byte_q == LAST_IDX);

	always_comb begin
		if (at_last) begin
			cur_byte = sum_q;
		end else if (byte_q >= SLOT0_IDX) begin
			cur_byte = slots_q[byte_slot];
		end else begin
			case (byte_q[2:0])
				3'd0:    cur_byte = hkrf_pkg::HDR_SYNC0;
				3'd1:    cur_byte = hkrf_pkg::HDR_SYNC1;
				3'd2:    cur_byte = hkrf_pkg::HDR_ADDR;
				3'd3:    cur_byte = hkrf_pkg::HDR_CMD;
				3'd4:    cur_byte = LEN_BYTE;
				3'd5:    cur_byte = mod_q;
				default: cur_byte = 8'h00;
			endcase
		end
	end

	assign out_busy = out_vld_q && !frame_ch.ready;
	assign out_load = ctl.go && ((ctl.op == hkrf_pkg::OP_EMIT) ||
		(ctl.op == hkrf_pkg::OP_SINGLE));

	assign stat = '{
		accept:   accept,
		noframe:  map_noframe,
		skip:     slot_rej || !oe_q,
		last:     at_last,
		out_busy: out_busy
	};

	// Control and report state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oe_q       <= 1'b1;
			shift_q    <= hkrf_pkg::SHIFT_FLAG_RST;
			altgr_q    <= hkrf_pkg::ALTGR_FLAG_RST;
			iso_repl_q <= hkrf_pkg::ISO_REPL_RST;
			iso_key_q  <= hkrf_pkg::ISO_KEY_RST;
			mod_q      <= 8'h00;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_q[i] <= 8'h00;
			end
			lay_vld_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hkrf_pkg::REG_OUTPUT_ENABLE:   oe_q       <= cfg_wdata[0];
					hkrf_pkg::REG_SHIFT_FLAG:      shift_q    <= cfg_wdata;
					hkrf_pkg::REG_ALTGR_FLAG:      altgr_q    <= cfg_wdata;
					hkrf_pkg::REG_ISO_REPLACEMENT: iso_repl_q <= cfg_wdata;
					hkrf_pkg::REG_ISO_KEY:         iso_key_q  <= cfg_wdata;
					default:                       oe_q       <= oe_q;
				endcase
			end
			// mark a loaded entry; unmarked entries read as unmapped
			if (ram_we) begin
				lay_vld_q[cmd_ch.layout_index] <= 1'b1;
			end
			case (ctl.op)
				hkrf_pkg::OP_MAP: begin
					if (cmd_q == hkrf_pkg::CMD_RELEASE_ALL) begin
						mod_q <= 8'h00;
						for (int i = 0; i < KEY_SLOTS; i++) begin
							slots_q[i] <= 8'h00;
						end
					end else begin
						mod_q <= (mod_q | mod_set) & ~mod_clr;
					end
				end
				hkrf_pkg::OP_SLOT: begin
					// add a new code to the first empty slot
					if (cmd_q == hkrf_pkg::CMD_PRESS && !present && free) begin
						slots_q[free_idx] <= code_q;
					end
					// drop every slot that holds a released nonzero code
					if (cmd_q == hkrf_pkg::CMD_RELEASE && code_q != 8'h00) begin
						for (int i = 0; i < KEY_SLOTS; i++) begin
							if (hit[i]) begin
								slots_q[i] <= 8'h00;
							end
						end
					end
				end
				default: begin
					mod_q <= mod_q;
				end
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (frame_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_ch.cmd;
			key_q     <= cmd_ch.key_code;
			ent_vld_q <= lay_vld_q[cmd_ch.key_code[hkrf_pkg::LAYOUT_AW-1:0]];
			status_q  <= 1'b0;
		end
		case (ctl.op)
			hkrf_pkg::OP_MAP: begin
				code_q <= map_code;
				if (map_rej) begin
					status_q <= 1'b1;
				end
			end
			hkrf_pkg::OP_SLOT: begin
				byte_q <= '0;
				sum_q  <= 8'h00;
				if (slot_rej) begin
					status_q <= 1'b1;
				end
			end
			hkrf_pkg::OP_EMIT: begin
				if (ctl.go) begin
					byte_q <= byte_q + BYTE_W'(1);
					sum_q  <= sum_q + cur_byte;
				end
			end
			default: begin
				code_q <= code_q;
			end
		endcase
		if (out_load) begin
			if (ctl.op == hkrf_pkg::OP_EMIT) begin
				out_byte_q <= cur_byte;
				out_bv_q   <= 1'b1;
				out_last_q <= at_last;
				out_st_q   <= 1'b0;
			end else begin
				out_byte_q <= 8'h00;
				out_bv_q   <= 1'b0;
				out_last_q <= 1'b1;
				out_st_q   <= status_q;
			end
		end
	end

	assign frame_ch.valid      = out_vld_q;
	assign frame_ch.frame_byte = out_byte_q;
	assign frame_ch.byte_valid = out_bv_q;
	assign frame_ch.last       = out_last_q;
	assign frame_ch.status     = out_st_q;

endmodule

// ----- rtl/hkrf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hkrf_pkg::LAYOUT_ENTRIES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/hkrf_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrf_seq
// Step counter and control ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module hkrf_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hkrf_pkg::stat_t        stat,
	output hkrf_pkg::ctl_t         ctl
);

	hkrf_pkg::step_t  step_q;
	hkrf_pkg::uword_t uw;
	logic             emits;
	logic             go;
	logic             jump;

	assign uw    = hkrf_pkg::ucode(step_q);
	// hold any output step while the output register is full and stalled
	assign emits = (uw.op == hkrf_pkg::OP_EMIT) || (uw.op == hkrf_pkg::OP_SINGLE);
	assign go    = !(emits && stat.out_busy);

	always_comb begin
		case (uw.cond)
			hkrf_pkg::C_ALWAYS:  jump = 1'b1;
			hkrf_pkg::C_ACCEPT:  jump = stat.accept;
			hkrf_pkg::C_NOFRAME: jump = stat.noframe;
			hkrf_pkg::C_SKIP:    jump = stat.skip;
			hkrf_pkg::C_LAST:    jump = stat.last;
			default:             jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hkrf_pkg::ST_IDLE;
		end else if (go) begin
			if (jump) begin
				step_q <= uw.target;
			end else if (!uw.hold) begin
				step_q <= hkrf_pkg::step_t'(step_q + 3'd1);
			end
		end
	end

	assign ctl = '{op: uw.op, go: go};

endmodule

// ----- rtl/hkrf_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrf_chk
// Port-level checks for the keyboard report framer, bound to the top level.
// ----------------------------------------------------------------------------
module hkrf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       frame_valid,
	input logic       frame_ready,
	input logic [7:0] frame_byte,
	input logic       byte_valid,
	input logic       last,
	input logic       status
);

	// a stalled transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte) &&
		$stable(byte_valid) && $stable(last) && $stable(status))
		else $error("frame transaction changed while stalled");

	// one command at a time: no command right after one is taken
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in flight");

	// a result without a frame byte is alone and carries zero
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !byte_valid |-> last && (frame_byte == 8'h00))
		else $error("non-frame result not single");

	// a rejected press never comes with a frame byte
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && status |-> !byte_valid)
		else $error("reject status on a frame byte");

endmodule

bind hid_key_report_framer_unit hkrf_chk u_hkrf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_ch.valid),
	.cmd_ready   (cmd_ch.ready),
	.frame_valid (frame_ch.valid),
	.frame_ready (frame_ch.ready),
	.frame_byte  (frame_ch.frame_byte),
	.byte_valid  (frame_ch.byte_valid),
	.last        (frame_ch.last),
	.status      (frame_ch.status)
);
